/* hdl/quadratic_root_solver_unit_defines.svh */
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QRS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define QRS_ASSERT(label, prop, msg)
`define QRS_ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* hdl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, root kind codes and the saturation helper of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
	localparam int COEF_WIDTH = 16;
	localparam int OUT_FRAC   = 16;
	// discriminant: signed, magnitude below 2^(2*COEF_WIDTH+1)
	localparam int DW   = 2 * COEF_WIDTH + 2;
	localparam int DMW  = 2 * COEF_WIDTH + 1;
	// square root digits
	localparam int SW   = COEF_WIDTH + 1;
	localparam int SRW  = SW + 3;
	// numerator magnitude |b|+s, dividend and divisor magnitudes
	localparam int NMW  = COEF_WIDTH + 2;
	localparam int NDW  = NMW + OUT_FRAC;
	localparam int DVW  = COEF_WIDTH + 1;
	localparam int QX   = (NDW > 33) ? NDW : 33;

	typedef enum logic [1:0] {
		KIND_TWO_REAL = 2'd0,
		KIND_DOUBLE   = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_A_ZERO   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0] value;
		logic        ovf;
	} sat_t;

	// signed saturation of a sign and quotient magnitude to 32 bits
	function automatic sat_t sat_q16(input logic neg, input logic [NDW-1:0] mag);
		logic [QX-1:0] ext;
		logic [31:0]   low;
		sat_t          r;
		ext = QX'(mag);
		low = ext[31:0];
		if (neg) begin
			if (ext > QX'(64'h8000_0000)) begin
				r.value = 32'h8000_0000;
				r.ovf   = 1'b1;
			end else begin
				r.value = 32'(~low + 32'd1);
				r.ovf   = 1'b0;
			end
		end else begin
			if (ext > QX'(64'h7FFF_FFFF)) begin
				r.value = 32'h7FFF_FFFF;
				r.ovf   = 1'b1;
			end else begin
				r.value = low;
				r.ovf   = 1'b0;
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* hdl/quadratic_root_solver_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Pipelined quadratic solver: discriminant, digit square root, two dividers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries coef_a, coef_b, coef_c (Q7.8).
//   Output channel out_valid/out_stall carries root_kind, first_value,
//   second_value (Q15.16) and overflow. One result per input transfer.
//   The stages are the products, the discriminant, one per square root
//   digit, one for the numerators, one per quotient bit of the two
//   dividers running side by side, and one for saturation into the
//   output register.
//   One transfer per cycle unless out_stall holds; every stage is a register.
//   The whole pipeline advances together; when the output holds a result and
//   out_stall is high, all stages hold and in_stall is raised, so nothing is
//   lost or repeated. Empty stages still accept while the output is empty.
//   Reset clears all valid bits; the pipeline starts empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [1:0]                              root_kind,
	output logic signed [31:0]                      first_value,
	output logic signed [31:0]                      second_value,
	output logic                                    overflow
);
	import qrs_pkg::*;

	localparam int CW = COEF_WIDTH;

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: products
	logic                  vld_s1;
	logic signed [2*CW-1:0] bb_s1, ac_s1;
	logic signed [CW-1:0]   a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
			a_s1  <= coef_a;
			b_s1  <= coef_b;
		end
	end

	// stage 2: discriminant and its magnitude
	logic signed [DW-1:0] d_c;
	logic                 vld_s2, dneg_s2, dzero_s2;
	logic [DMW-1:0]       dmag_s2;
	logic signed [CW-1:0] a_s2, b_s2;

	assign d_c = DW'(bb_s1) - (DW'(ac_s1) <<< 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s2  <= d_c[DW-1];
			dzero_s2 <= (d_c == '0);
			dmag_s2  <= d_c[DW-1] ? DMW'(-d_c) : DMW'(d_c);
			a_s2     <= a_s1;
			b_s2     <= b_s1;
		end
	end

	// square root pipeline, one digit per stage
	logic                 sq_vld_s  [0:SW];
	logic [2*SW-1:0]      sq_x_s    [0:SW];
	logic [SRW-1:0]       sq_rem_s  [0:SW];
	logic [SW-1:0]        sq_root_s [0:SW];
	logic                 sq_dneg_s [0:SW];
	logic                 sq_dz_s   [0:SW];
	logic signed [CW-1:0] sq_a_s    [0:SW];
	logic signed [CW-1:0] sq_b_s    [0:SW];

	assign sq_vld_s[0]  = vld_s2;
	assign sq_x_s[0]    = (2*SW)'(dmag_s2);
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_dneg_s[0] = dneg_s2;
	assign sq_dz_s[0]   = dzero_s2;
	assign sq_a_s[0]    = a_s2;
	assign sq_b_s[0]    = b_s2;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		logic [SRW-1:0] pre, trial;
		assign pre   = {sq_rem_s[k][SRW-3:0], sq_x_s[k][2*SW-1:2*SW-2]};
		assign trial = SRW'({sq_root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else if (adv) sq_vld_s[k+1] <= sq_vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_x_s[k+1]    <= {sq_x_s[k][2*SW-3:0], 2'b00};
				if (pre >= trial) begin
					sq_rem_s[k+1]  <= pre - trial;
					sq_root_s[k+1] <= {sq_root_s[k][SW-2:0], 1'b1};
				end else begin
					sq_rem_s[k+1]  <= pre;
					sq_root_s[k+1] <= {sq_root_s[k][SW-2:0], 1'b0};
				end
				sq_dneg_s[k+1] <= sq_dneg_s[k];
				sq_dz_s[k+1]   <= sq_dz_s[k];
				sq_a_s[k+1]    <= sq_a_s[k];
				sq_b_s[k+1]    <= sq_b_s[k];
			end
		end
	end

	// numerator stage: kind, numerators in sign and magnitude, divisor
	logic signed [NMW:0] nb_c, sx_c, n1_c, n2_c;
	kind_t               kind_c;
	logic                vld_n;
	logic                n_vld_s3;
	kind_t               kind_s3;
	logic                s1neg_s3, s2neg_s3;
	logic [NMW-1:0]      m1_s3, m2_s3;
	logic [DVW-1:0]      dv_s3;

	assign vld_n = sq_vld_s[SW];
	assign nb_c  = -(NMW+1)'(sq_b_s[SW]);
	assign sx_c  = (NMW+1)'({1'b0, sq_root_s[SW]});

	always_comb begin
		if (sq_a_s[SW] == '0) begin
			kind_c = KIND_A_ZERO;
			n1_c   = '0;
			n2_c   = '0;
		end else if (sq_dz_s[SW]) begin
			kind_c = KIND_DOUBLE;
			n1_c   = nb_c;
			n2_c   = '0;
		end else if (sq_dneg_s[SW]) begin
			kind_c = KIND_COMPLEX;
			n1_c   = nb_c;
			n2_c   = sx_c;
		end else begin
			kind_c = KIND_TWO_REAL;
			n1_c   = nb_c - sx_c;
			n2_c   = nb_c + sx_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_vld_s3 <= 1'b0;
		else if (adv) n_vld_s3 <= vld_n;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3  <= kind_c;
			s1neg_s3 <= n1_c[NMW] ^ sq_a_s[SW][CW-1];
			s2neg_s3 <= n2_c[NMW] ^ sq_a_s[SW][CW-1];
			m1_s3    <= n1_c[NMW] ? NMW'(-n1_c) : NMW'(n1_c);
			m2_s3    <= n2_c[NMW] ? NMW'(-n2_c) : NMW'(n2_c);
			dv_s3    <= sq_a_s[SW][CW-1] ? DVW'(-(DVW+1)'(sq_a_s[SW]) <<< 1)
			                             : DVW'((DVW+1)'(sq_a_s[SW]) <<< 1);
		end
	end

	// two restoring dividers, one quotient bit per stage
	logic           dv_vld_s  [0:NDW];
	kind_t          dv_kind_s [0:NDW];
	logic           dv_n1_s   [0:NDW];
	logic           dv_n2_s   [0:NDW];
	logic [DVW-1:0] dv_den_s  [0:NDW];
	logic [NDW-1:0] dv_x1_s   [0:NDW];
	logic [NDW-1:0] dv_x2_s   [0:NDW];
	logic [DVW-1:0] dv_r1_s   [0:NDW];
	logic [DVW-1:0] dv_r2_s   [0:NDW];
	logic [NDW-1:0] dv_q1_s   [0:NDW];
	logic [NDW-1:0] dv_q2_s   [0:NDW];

	assign dv_vld_s[0]  = n_vld_s3;
	assign dv_kind_s[0] = kind_s3;
	assign dv_n1_s[0]   = s1neg_s3;
	assign dv_n2_s[0]   = s2neg_s3;
	assign dv_den_s[0]  = dv_s3;
	assign dv_x1_s[0]   = {m1_s3, {OUT_FRAC{1'b0}}};
	assign dv_x2_s[0]   = {m2_s3, {OUT_FRAC{1'b0}}};
	assign dv_r1_s[0]   = '0;
	assign dv_r2_s[0]   = '0;
	assign dv_q1_s[0]   = '0;
	assign dv_q2_s[0]   = '0;

	for (genvar k = 0; k < NDW; k++) begin : g_div
		logic [DVW:0] p1, p2, dd;
		logic         t1, t2;
		assign p1 = {dv_r1_s[k], dv_x1_s[k][NDW-1]};
		assign p2 = {dv_r2_s[k], dv_x2_s[k][NDW-1]};
		assign dd = {1'b0, dv_den_s[k]};
		assign t1 = (p1 >= dd);
		assign t2 = (p2 >= dd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k+1] <= 1'b0;
			else if (adv) dv_vld_s[k+1] <= dv_vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_kind_s[k+1] <= dv_kind_s[k];
				dv_n1_s[k+1]   <= dv_n1_s[k];
				dv_n2_s[k+1]   <= dv_n2_s[k];
				dv_den_s[k+1]  <= dv_den_s[k];
				dv_x1_s[k+1]   <= {dv_x1_s[k][NDW-2:0], 1'b0};
				dv_x2_s[k+1]   <= {dv_x2_s[k][NDW-2:0], 1'b0};
				dv_r1_s[k+1]   <= t1 ? DVW'(p1 - dd) : DVW'(p1);
				dv_r2_s[k+1]   <= t2 ? DVW'(p2 - dd) : DVW'(p2);
				dv_q1_s[k+1]   <= {dv_q1_s[k][NDW-2:0], t1};
				dv_q2_s[k+1]   <= {dv_q2_s[k][NDW-2:0], t2};
			end
		end
	end

	// output register: saturation and overflow
	sat_t  r1_c, r2_c;
	kind_t kind_q;

	assign r1_c = sat_q16(dv_n1_s[NDW], dv_q1_s[NDW]);
	assign r2_c = sat_q16(dv_n2_s[NDW], dv_q2_s[NDW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dv_vld_s[NDW];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= dv_kind_s[NDW];
			// a zero divides by zero, so its quotients are dropped
			if (dv_kind_s[NDW] == KIND_A_ZERO) begin
				first_value  <= '0;
				second_value <= '0;
				overflow     <= 1'b0;
			end else begin
				first_value  <= r1_c.value;
				second_value <= r2_c.value;
				overflow     <= r1_c.ovf | r2_c.ovf;
			end
		end
	end
	assign root_kind = kind_q;

	// checks
	`QRS_ASSERT(a_zero_clean, (out_valid && kind_q == KIND_A_ZERO) |-> (first_value == 32'sd0 && second_value == 32'sd0 && !overflow), "a zero result not cleared")
	`QRS_ASSERT(double_second_zero, (out_valid && kind_q == KIND_DOUBLE) |-> (second_value == 32'sd0), "double root second value not zero")
	`QRS_ASSERT(ovf_means_sat, (out_valid && overflow) |-> (first_value == 32'sh7FFF_FFFF || first_value == 32'sh8000_0000 || second_value == 32'sh7FFF_FFFF || second_value == 32'sh8000_0000), "overflow without saturated value")
	`QRS_ASSERT(stall_holds_input, (out_valid && out_stall) |-> in_stall, "input taken while pipeline held")
endmodule
`default_nettype wire
